### design/two_way_traffic_light_sequencer_core_defines.svh
// Assertion macros used by the traffic light sequencer port checker
`ifndef TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_CORE_DEFINES_SVH
`define TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define TWTLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define TWTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/twtls_pkg.sv
// Shared types, constants and reset values of the traffic light sequencer
`default_nettype none

package twtls_pkg;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_SOUTH,
        PH_WEST,
        PH_MANUAL
    } t_phase;

    // Lamp codes
    localparam logic [1:0] LT_OFF    = 2'd0;
    localparam logic [1:0] LT_RED    = 2'd1;
    localparam logic [1:0] LT_YELLOW = 2'd2;
    localparam logic [1:0] LT_GREEN  = 2'd3;

    // Register indexes on the APB port
    localparam int unsigned  ADDR_W         = 5;
    localparam logic [2:0]   RI_SOUTH_GREEN = 3'd0;
    localparam logic [2:0]   RI_WEST_GREEN  = 3'd1;
    localparam logic [2:0]   RI_YELLOW      = 3'd2;
    localparam logic [2:0]   RI_AUTO_HOLD   = 3'd3;
    localparam logic [2:0]   RI_MANUAL_HOLD = 3'd4;

    // Register reset values
    localparam logic [6:0] SOUTH_GREEN_RST = 7'd15;
    localparam logic [6:0] WEST_GREEN_RST  = 7'd23;
    localparam logic [3:0] YELLOW_RST      = 4'd3;
    localparam logic [7:0] AUTO_HOLD_RST   = 8'd30;
    localparam logic [7:0] MANUAL_HOLD_RST = 8'd100;

    // Largest count the two digits can show
    localparam logic [6:0] COUNT_MAX = 7'd99;

    typedef struct packed {
        logic [6:0] south_green_count;
        logic [6:0] west_green_count;
        logic [3:0] yellow_count;
        logic [7:0] auto_hold_ticks;
        logic [7:0] manual_hold_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [6:0] countdown_value;
        logic [7:0] hold_ticks_left;
        logic [1:0] manual_position;
        logic       press_pending;
        logic [1:0] last_west_light;
        logic [1:0] last_south_light;
        logic [3:0] saved_yellow_count;
    } t_state;

    typedef struct packed {
        logic [1:0] west_light;
        logic [1:0] south_light;
        logic [3:0] count_tens;
        logic [3:0] count_ones;
    } t_result;

    localparam t_cfg CFG_RST = '{
        south_green_count: SOUTH_GREEN_RST,
        west_green_count:  WEST_GREEN_RST,
        yellow_count:      YELLOW_RST,
        auto_hold_ticks:   AUTO_HOLD_RST,
        manual_hold_ticks: MANUAL_HOLD_RST
    };

    localparam t_state STATE_RST = '{
        phase:              PH_SOUTH,
        countdown_value:    7'd0,
        hold_ticks_left:    8'd0,
        manual_position:    2'd0,
        press_pending:      1'b0,
        last_west_light:    LT_OFF,
        last_south_light:   LT_OFF,
        saved_yellow_count: 4'd0
    };

endpackage

`default_nettype wire

### design/twtls_in_if.sv
// Tick input channel: mode switch level and button press
`default_nettype none

interface twtls_in_if;
    logic valid;
    logic ready;
    logic auto_mode;
    logic button_press;

    modport source (output valid, output auto_mode, output button_press, input ready);
    modport sink   (input valid, input auto_mode, input button_press, output ready);
endinterface

`default_nettype wire

### design/twtls_out_if.sv
// Display output channel: lamps and countdown digits
`default_nettype none

interface twtls_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] west_light;
    logic [1:0] south_light;
    logic [3:0] count_tens;
    logic [3:0] count_ones;

    modport source (output valid, output west_light, output south_light,
                    output count_tens, output count_ones, input ready);
    modport sink   (input valid, input west_light, input south_light,
                    input count_tens, input count_ones, output ready);
endinterface

`default_nettype wire

### design/twtls_cfg.sv
// APB register file holding the sequencer timing registers
`default_nettype none

module twtls_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [twtls_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output twtls_pkg::t_cfg                  o_cfg
);
    import twtls_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                RI_SOUTH_GREEN: r_cfg.south_green_count <= pwdata[6:0];
                RI_WEST_GREEN:  r_cfg.west_green_count  <= pwdata[6:0];
                RI_YELLOW:      r_cfg.yellow_count      <= pwdata[3:0];
                RI_AUTO_HOLD:   r_cfg.auto_hold_ticks   <= pwdata[7:0];
                RI_MANUAL_HOLD: r_cfg.manual_hold_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            RI_SOUTH_GREEN: prdata = {25'd0, r_cfg.south_green_count};
            RI_WEST_GREEN:  prdata = {25'd0, r_cfg.west_green_count};
            RI_YELLOW:      prdata = {28'd0, r_cfg.yellow_count};
            RI_AUTO_HOLD:   prdata = {24'd0, r_cfg.auto_hold_ticks};
            RI_MANUAL_HOLD: prdata = {24'd0, r_cfg.manual_hold_ticks};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### design/twtls_step.sv
// One-tick state update and display decode of the sequencer
`default_nettype none

module twtls_step (
    input  wire twtls_pkg::t_cfg    i_cfg,
    input  wire twtls_pkg::t_state  i_state,
    input  wire logic               i_auto_mode,
    input  wire logic               i_button_press,
    output twtls_pkg::t_state       o_state,
    output twtls_pkg::t_result      o_result
);
    import twtls_pkg::*;

    function automatic logic [6:0] min1_7(input logic [6:0] v);
        min1_7 = (v == 7'd0) ? 7'd1 : v;
    endfunction

    function automatic logic [7:0] min1_8(input logic [7:0] v);
        min1_8 = (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic t_phase other_road(input t_phase p);
        other_road = (p == PH_WEST) ? PH_SOUTH : PH_WEST;
    endfunction

    t_state      ns;
    logic [1:0]  wl;
    logic [1:0]  sl;
    logic [6:0]  cnt;
    logic [6:0]  shown;
    logic [1:0]  off;
    logic [1:0]  stage;
    logic        yel;
    logic [3:0]  ylen;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;

    always_comb begin
        ns    = i_state;
        wl    = LT_RED;
        sl    = LT_RED;
        cnt   = 7'd0;
        off   = 2'd0;
        stage = 2'd0;
        yel   = 1'b0;
        ylen  = 4'd0;

        if (i_auto_mode) begin
            // Leaving manual mode restarts with a fresh south phase
            if (ns.phase == PH_MANUAL) begin
                ns.phase           = PH_SOUTH;
                ns.countdown_value = 7'd0;
                ns.hold_ticks_left = 8'd0;
            end
            // Step boundary
            if (ns.hold_ticks_left == 8'd0) begin
                if (ns.countdown_value > 7'd1) begin
                    ns.countdown_value = ns.countdown_value - 7'd1;
                    ns.press_pending   = 1'b0;
                end else begin
                    if (ns.countdown_value == 7'd1) begin
                        ns.phase = other_road(ns.phase);
                    end
                    ns.countdown_value = min1_7((ns.phase == PH_WEST) ?
                        i_cfg.west_green_count : i_cfg.south_green_count);
                    // Pending press skips the phase just starting
                    if (ns.press_pending) begin
                        ns.press_pending   = 1'b0;
                        ns.phase           = other_road(ns.phase);
                        ns.countdown_value = min1_7((ns.phase == PH_WEST) ?
                            i_cfg.west_green_count : i_cfg.south_green_count);
                    end
                end
                ns.hold_ticks_left = min1_8(i_cfg.auto_hold_ticks);
            end
            // Lamps for the moving road
            yel = (ns.countdown_value <= {3'd0, i_cfg.yellow_count});
            if (ns.phase == PH_SOUTH) begin
                wl = LT_RED;
                sl = yel ? LT_YELLOW : LT_GREEN;
            end else begin
                wl = yel ? LT_YELLOW : LT_GREEN;
                sl = LT_RED;
            end
            if (yel) begin
                ns.saved_yellow_count = ns.countdown_value[3:0];
            end
            ns.last_west_light  = wl;
            ns.last_south_light = sl;
            cnt                 = ns.countdown_value;
        end else begin
            // Entering manual mode clears the count and examines at once
            if (ns.phase != PH_MANUAL) begin
                ns.phase           = PH_MANUAL;
                ns.countdown_value = 7'd0;
                ns.hold_ticks_left = 8'd0;
            end
            // Align the manual cycle to the last automatic lamps
            if (ns.last_west_light == LT_YELLOW) begin
                off = 2'd3;
            end else if (ns.last_south_light == LT_YELLOW) begin
                off = 2'd1;
            end else if (ns.last_south_light != LT_GREEN && ns.last_west_light == LT_GREEN) begin
                off = 2'd2;
            end else begin
                off = 2'd0;
            end
            // Step boundary
            if (ns.hold_ticks_left == 8'd0) begin
                if (ns.countdown_value != 7'd0) begin
                    ns.countdown_value = ns.countdown_value - 7'd1;
                    if (ns.countdown_value == 7'd0) begin
                        ns.manual_position    = ns.manual_position + 2'd1;
                        ns.saved_yellow_count = i_cfg.yellow_count;
                    end
                end
                if (ns.countdown_value == 7'd0) begin
                    stage = ns.manual_position + off;
                    if (stage[0]) begin
                        // Interrupted yellow resumes from its saved count
                        ylen = (ns.manual_position == 2'd0 && off[0]) ?
                            ns.saved_yellow_count : i_cfg.yellow_count;
                        ns.countdown_value = min1_7({3'd0, ylen});
                    end
                end
                ns.hold_ticks_left = min1_8(i_cfg.manual_hold_ticks);
            end
            stage = ns.manual_position + off;
            unique case (stage)
                2'd0: begin wl = LT_RED;    sl = LT_GREEN;  end
                2'd1: begin wl = LT_RED;    sl = LT_YELLOW; end
                2'd2: begin wl = LT_GREEN;  sl = LT_RED;    end
                2'd3: begin wl = LT_YELLOW; sl = LT_RED;    end
            endcase
            cnt = stage[0] ? ns.countdown_value : 7'd0;
        end

        ns.hold_ticks_left = ns.hold_ticks_left - 8'd1;

        // Button press: latch pending, advance position unless a manual yellow runs
        if (i_button_press) begin
            ns.press_pending = 1'b1;
            if (!(ns.phase == PH_MANUAL && ns.countdown_value != 7'd0)) begin
                ns.manual_position = ns.manual_position + 2'd1;
            end
        end
    end

    // Digit split: divide by ten through a reciprocal, exact below 160
    assign shown    = (cnt > COUNT_MAX) ? COUNT_MAX : cnt;
    assign prod     = {8'd0, shown} * 15'd205;
    assign tens     = prod[14:11];
    assign tens_x10 = {tens, 3'd0} + {2'd0, tens, 1'b0};

    assign o_state              = ns;
    assign o_result.west_light  = wl;
    assign o_result.south_light = sl;
    assign o_result.count_tens  = tens;
    assign o_result.count_ones  = 4'(shown - tens_x10);

endmodule

`default_nettype wire

### design/two_way_traffic_light_sequencer_core.sv
// Tick beats pass an input register, the step logic and an output register.
// Throughput: one tick per cycle unless the display stalls; the state register is
// updated in a single pass. The two registers part the channels, so a stalled display
// still lets one more tick in. Reset (synchronous, active low) loads the timing
// registers with their defaults, starts in the south phase with no lamps recorded.
`default_nettype none

module two_way_traffic_light_sequencer_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    twtls_in_if.sink                          i_tick,
    twtls_out_if.source                       o_disp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [twtls_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import twtls_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_in_valid;
    logic    r_in_auto;
    logic    r_in_press;
    logic    r_out_valid;
    logic    advance;

    twtls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    twtls_step u_step (
        .i_cfg          (cfg),
        .i_state        (r_state),
        .i_auto_mode    (r_in_auto),
        .i_button_press (r_in_press),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Handshake: the input stage moves on when the output register is free
    assign advance      = r_in_valid && (!r_out_valid || o_disp.ready);
    assign i_tick.ready = !r_in_valid || advance;

    // Control and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RST;
        end else begin
            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_disp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_auto  <= i_tick.auto_mode;
            r_in_press <= i_tick.button_press;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_disp.valid       = r_out_valid;
    assign o_disp.west_light  = r_result.west_light;
    assign o_disp.south_light = r_result.south_light;
    assign o_disp.count_tens  = r_result.count_tens;
    assign o_disp.count_ones  = r_result.count_ones;

endmodule

`default_nettype wire

### design/twtls_chk.sv
// Port-level checker for the traffic light sequencer, bound to the top level
`default_nettype none
`include "two_way_traffic_light_sequencer_core_defines.svh"

module twtls_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_west_light,
    input wire logic [1:0] i_south_light,
    input wire logic [3:0] i_count_tens,
    input wire logic [3:0] i_count_ones
);
    import twtls_pkg::*;

    // A stalled display beat holds
    `TWTLS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_west_light) && $stable(i_south_light) && $stable(i_count_tens) && $stable(i_count_ones), "display beat changed under stall")

    // Input backpressure only when both stages are full and the display stalls
    `TWTLS_ASSERT_NOW(a_in_stall, !i_in_ready, i_out_valid && !i_out_ready, "tick refused with room left")

    // A display beat appearing from empty comes from a tick that went straight through the input register
    `TWTLS_ASSERT_NOW(a_out_origin, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2), "display beat without a tick")

    // At least one road is red and both digits are decimal
    `TWTLS_ASSERT_NOW(a_out_sane, i_out_valid, (i_west_light == LT_RED || i_south_light == LT_RED) && i_count_tens <= 4'd9 && i_count_ones <= 4'd9, "bad display beat")

endmodule

bind two_way_traffic_light_sequencer_core twtls_chk u_twtls_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_tick.valid),
    .i_in_ready    (i_tick.ready),
    .i_out_valid   (o_disp.valid),
    .i_out_ready   (o_disp.ready),
    .i_west_light  (o_disp.west_light),
    .i_south_light (o_disp.south_light),
    .i_count_tens  (o_disp.count_tens),
    .i_count_ones  (o_disp.count_ones)
);

`default_nettype wire

### tb/two_way_traffic_light_sequencer_core_checker.sv
// Checker for the traffic light sequencer: predicts every display beat and compares it
`timescale 1ns / 1ps

module two_way_traffic_light_sequencer_core_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    twtls_in_if                               i_tick,
    twtls_out_if                              i_disp,
    input  wire logic                         i_psel,
    input  wire logic                         i_penable,
    input  wire logic                         i_pwrite,
    input  wire logic                         i_pready,
    input  wire logic [twtls_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                  i_pwdata,
    output int unsigned                       o_mismatches,
    output int unsigned                       o_pending,
    output int unsigned                       o_beats
);
    import twtls_pkg::*;

    // Positions of the manual cycle
    localparam logic [1:0] POS_SOUTH_GO     = 2'd0;
    localparam logic [1:0] POS_SOUTH_YELLOW = 2'd1;
    localparam logic [1:0] POS_WEST_GO      = 2'd2;
    localparam logic [1:0] POS_WEST_YELLOW  = 2'd3;

    localparam int unsigned REPORT_LIMIT = 10;

    // Timing registers as last written
    t_cfg       timing;

    // Predicted sequencer state
    t_phase     seq_phase;
    logic [6:0] countdown;
    logic [7:0] hold_left;
    logic [1:0] man_pos;
    logic       press_pend;
    logic [1:0] last_west;
    logic [1:0] last_south;
    logic [3:0] saved_yellow;

    // Display beats still owed by the block, oldest first
    t_result    lamps_due [$];

    int unsigned errors;
    int unsigned beats_seen;

    // A start, length or hold of zero behaves as one
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic t_phase other_road(input t_phase p);
        return (p == PH_WEST) ? PH_SOUTH : PH_WEST;
    endfunction

    task automatic load_green();
        countdown = 7'(at_least_one(8'((seq_phase == PH_WEST) ? timing.west_green_count
                                                              : timing.south_green_count)));
    endtask

    // One display tick of the sequencer
    task automatic advance_sequencer(input logic auto_m, input logic press,
                                     output t_result r);
        logic [1:0] offset;
        logic [1:0] stage;
        logic       yellow_on;
        logic [6:0] shown;
        logic [1:0] west;
        logic [1:0] south;

        if (auto_m) begin
            // automatic: coming from manual restarts with a fresh south phase
            if (seq_phase == PH_MANUAL) begin
                seq_phase = PH_SOUTH;
                countdown = 7'd0;
                hold_left = 8'd0;
            end
            if (hold_left == 8'd0) begin
                if (countdown > 7'd1) begin
                    countdown--;
                    press_pend = 1'b0;
                end else begin
                    if (countdown == 7'd1)
                        seq_phase = other_road(seq_phase);
                    load_green();
                    // pending press skips the phase just started
                    if (press_pend) begin
                        press_pend = 1'b0;
                        seq_phase = other_road(seq_phase);
                        load_green();
                    end
                end
                hold_left = at_least_one(timing.auto_hold_ticks);
            end
            yellow_on = (countdown <= 7'(timing.yellow_count));
            if (seq_phase == PH_SOUTH) begin
                west  = LT_RED;
                south = yellow_on ? LT_YELLOW : LT_GREEN;
            end else begin
                west  = yellow_on ? LT_YELLOW : LT_GREEN;
                south = LT_RED;
            end
            if (yellow_on)
                saved_yellow = countdown[3:0];
            last_west  = west;
            last_south = south;
            shown      = countdown;
        end else begin
            // manual: entering clears the count so the position is examined now
            if (seq_phase != PH_MANUAL) begin
                seq_phase = PH_MANUAL;
                countdown = 7'd0;
                hold_left = 8'd0;
            end
            // align the cycle to the last automatic lamps
            if (last_west == LT_YELLOW)
                offset = POS_WEST_YELLOW;
            else if (last_south == LT_YELLOW)
                offset = POS_SOUTH_YELLOW;
            else if (last_south != LT_GREEN && last_west == LT_GREEN)
                offset = POS_WEST_GO;
            else
                offset = POS_SOUTH_GO;
            if (hold_left == 8'd0) begin
                if (countdown > 7'd0) begin
                    countdown--;
                    if (countdown == 7'd0) begin
                        man_pos++;
                        saved_yellow = timing.yellow_count;
                    end
                end
                if (countdown == 7'd0) begin
                    stage = man_pos + offset;
                    // interrupted yellow resumes from the saved count
                    if (stage[0])
                        countdown = 7'(at_least_one(8'((man_pos == 2'd0 && offset[0])
                                                       ? saved_yellow : timing.yellow_count)));
                end
                hold_left = at_least_one(timing.manual_hold_ticks);
            end
            stage = man_pos + offset;
            unique case (stage)
                POS_SOUTH_GO:     begin west = LT_RED;    south = LT_GREEN;  end
                POS_SOUTH_YELLOW: begin west = LT_RED;    south = LT_YELLOW; end
                POS_WEST_GO:      begin west = LT_GREEN;  south = LT_RED;    end
                default:          begin west = LT_YELLOW; south = LT_RED;    end
            endcase
            shown = stage[0] ? countdown : 7'd0;
        end
        hold_left--;

        if (shown > COUNT_MAX)
            shown = COUNT_MAX;
        r.west_light  = west;
        r.south_light = south;
        r.count_tens  = 4'(shown / 7'd10);
        r.count_ones  = 4'(shown % 7'd10);

        // press: arms a skip, steps the manual cycle unless a manual yellow runs
        if (press) begin
            press_pend = 1'b1;
            if (!(seq_phase == PH_MANUAL && countdown > 7'd0))
                man_pos++;
        end
    endtask

    // Watch register writes, tick beats and display beats
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        t_result got;

        if (!i_rst_n) begin
            timing       = CFG_RST;
            seq_phase    = PH_SOUTH;
            countdown    = 7'd0;
            hold_left    = 8'd0;
            man_pos      = 2'd0;
            press_pend   = 1'b0;
            last_west    = LT_OFF;
            last_south   = LT_OFF;
            saved_yellow = 4'd0;
            errors       = 0;
            beats_seen   = 0;
            lamps_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                unique case (i_paddr[ADDR_W-1:2])
                    RI_SOUTH_GREEN: timing.south_green_count = i_pwdata[6:0];
                    RI_WEST_GREEN:  timing.west_green_count  = i_pwdata[6:0];
                    RI_YELLOW:      timing.yellow_count      = i_pwdata[3:0];
                    RI_AUTO_HOLD:   timing.auto_hold_ticks   = i_pwdata[7:0];
                    RI_MANUAL_HOLD: timing.manual_hold_ticks = i_pwdata[7:0];
                    default: ;
                endcase
            end

            if (i_tick.valid && i_tick.ready) begin
                advance_sequencer(i_tick.auto_mode, i_tick.button_press, want);
                lamps_due.push_back(want);
            end

            if (i_disp.valid && i_disp.ready) begin
                got.west_light  = i_disp.west_light;
                got.south_light = i_disp.south_light;
                got.count_tens  = i_disp.count_tens;
                got.count_ones  = i_disp.count_ones;
                beats_seen++;
                if (lamps_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("display beat %0d arrived with none owed: W%0d S%0d %0d%0d",
                                 beats_seen, got.west_light, got.south_light,
                                 got.count_tens, got.count_ones);
                end else begin
                    want = lamps_due.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("display beat %0d: expected W%0d S%0d %0d%0d, got W%0d S%0d %0d%0d",
                                     beats_seen, want.west_light, want.south_light,
                                     want.count_tens, want.count_ones,
                                     got.west_light, got.south_light,
                                     got.count_tens, got.count_ones);
                    end
                end
            end
        end

        o_mismatches <= errors;
        o_pending    <= lamps_due.size();
        o_beats      <= beats_seen;
    end

endmodule

### tb/two_way_traffic_light_sequencer_core_test.sv
// Top of the traffic light sequencer bench: clock, reset, tick stimulus and verdict
`timescale 1ns / 1ps

module two_way_traffic_light_sequencer_core_test;
    import twtls_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    twtls_in_if  tick ();
    twtls_out_if disp ();

    int unsigned mismatches;
    int unsigned pending;
    int unsigned beats;

    // Run statistics
    int unsigned ticks_sent;
    int unsigned auto_ticks;
    int unsigned presses;
    int unsigned settings_used;

    // Set while a run of ticks goes out back to back
    bit steady;

    two_way_traffic_light_sequencer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .o_disp  (disp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    two_way_traffic_light_sequencer_core_checker u_lamp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_disp       (disp),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_beats      (beats)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold until every owed display beat has come back
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_tick(input bit auto_m, input bit press);
        int unsigned gap;
        tick.valid        <= 1'b1;
        tick.auto_mode    <= auto_m;
        tick.button_press <= press;
        @(posedge i_clk);
        while (!tick.ready) @(posedge i_clk);
        ticks_sent++;
        auto_ticks += auto_m;
        presses    += press;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // New timing, written only once the block has gone quiet
    task automatic set_timing(input logic [6:0] south_go, input logic [6:0] west_go,
                              input logic [3:0] yellow, input logic [7:0] auto_hold,
                              input logic [7:0] manual_hold);
        tick.valid <= 1'b0;
        wait_drained();
        apb_write(RI_SOUTH_GREEN, 32'(south_go));
        apb_write(RI_WEST_GREEN,  32'(west_go));
        apb_write(RI_YELLOW,      32'(yellow));
        apb_write(RI_AUTO_HOLD,   32'(auto_hold));
        apb_write(RI_MANUAL_HOLD, 32'(manual_hold));
        settings_used++;
    endtask

    // Runs of one mode with random presses, plus bursts of mode chatter
    task automatic send_random(input int unsigned count);
        int unsigned made;
        int unsigned run_len;
        int unsigned k;
        bit          auto_m;
        bit          chatter;
        bit          press;
        made = 0;
        while (made < count) begin
            chatter = ($urandom_range(0, 9) == 0);
            steady  = ($urandom_range(0, 3) == 0);
            auto_m  = 1'($urandom_range(0, 1));
            if (chatter)
                run_len = $urandom_range(1, 6);
            else if ($urandom_range(0, 5) == 0)
                run_len = $urandom_range(30, 80);
            else
                run_len = $urandom_range(1, 25);
            for (k = 0; k < run_len && made < count; k++) begin
                if (chatter) begin
                    auto_m = 1'($urandom_range(0, 1));
                    press  = 1'($urandom_range(0, 1));
                end else begin
                    press = auto_m ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) == 0);
                end
                send_tick(auto_m, press);
                made++;
            end
        end
    endtask

    // Display side: random stalls, one long hold-off once traffic is flowing
    initial begin : display_sink
        int unsigned run_len;
        int unsigned stall;
        int unsigned beats_taken;
        bit          long_done;
        beats_taken = 0;
        long_done   = 1'b0;
        forever begin
            disp.ready <= 1'b1;
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
            repeat (run_len) begin
                @(posedge i_clk);
                if (disp.valid && disp.ready)
                    beats_taken++;
            end
            if (!long_done && beats_taken >= 400) begin
                long_done = 1'b1;
                stall = 150;
            end else begin
                stall = idle_len();
            end
            if (stall != 0) begin
                disp.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Stimulus: directed opening, then several timing settings with random ticks
    initial begin : stimulus
        string       directed;
        int unsigned i;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        tick.valid        <= 1'b0;
        tick.auto_mode    <= 1'b0;
        tick.button_press <= 1'b0;
        ticks_sent    = 0;
        auto_ticks    = 0;
        presses       = 0;
        settings_used = 0;
        steady        = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short counts so skips, yellows and manual alignment show up quickly
        // a: auto, A: auto with press, m: manual, M: manual with press
        set_timing(7'd4, 7'd5, 4'd2, 8'd1, 8'd1);
        directed = "aaAaaaaammMmmMMmmmaAamMm";
        for (i = 0; i < directed.len(); i++)
            send_tick(directed[i] == "a" || directed[i] == "A",
                      directed[i] == "A" || directed[i] == "M");
        send_random(150);

        // zero values behave as one
        set_timing(7'd0, 7'd0, 4'd0, 8'd0, 8'd0);
        send_random(150);

        // counts past 99 and the widest yellow
        set_timing(7'd127, 7'd99, 4'd15, 8'd1, 8'd2);
        send_random(200);

        // the reset timing written back
        set_timing(SOUTH_GREEN_RST, WEST_GREEN_RST, YELLOW_RST, AUTO_HOLD_RST,
                   MANUAL_HOLD_RST);
        send_random(100);

        // longest holds
        set_timing(7'd99, 7'd4, 4'd9, 8'd255, 8'd255);
        send_random(60);

        repeat (3) begin
            set_timing(7'($urandom_range(0, 12)), 7'($urandom_range(0, 12)),
                       4'($urandom_range(0, 15)), 8'($urandom_range(0, 3)),
                       8'($urandom_range(0, 3)));
            send_random(150);
        end

        tick.valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d ticks (%0d automatic, %0d with a press) under %0d timing settings",
                 ticks_sent, auto_ticks, presses, settings_used);
        $display("Compared %0d display beats, %0d mismatches", beats, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
